// ===== hw/rtl/dnsenc_pkg.sv =====
// Package for the DNS name wire-format encoder.
// Holds the beat types of both channels and fixed character codes.
// No dependencies.
package dnsenc_pkg;

    // Label separator in a dotted name.
    localparam logic [7:0] DOT_CHAR = 8'd46;

    // Byte written as the name terminator.
    localparam logic [7:0] ZERO_BYTE = 8'd0;

    typedef struct packed {
        logic [7:0] character;
        logic       is_end;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] write_offset;
        logic [7:0] write_value;
        logic       write_valid;
        logic       name_done;
        logic       name_error;
    } out_beat_t;

endpackage

// ===== hw/rtl/dns_name_label_encoder_core.sv =====
// Top level of the DNS name wire-format encoder.
// Depends on dnsenc_pkg for the beat types and character codes.
//
// The encoder takes a dotted domain name one character per input beat,
// closed by a beat with is_end set, and emits byte writes that build the
// name in DNS wire format: every label byte is written at its place after
// the label start as it arrives, the label's length byte is patched in at
// the label start on a dot or at the end, and the end beat writes the zero
// terminator (name_done set). An empty label before a dot, a label longer
// than MAX_LABEL_BYTES, or any write at an offset of MAX_NAME_BYTES or
// beyond marks the name as rejected; further characters are then dropped
// and the end beat yields a single beat with name_error and name_done set
// and write_valid clear. A character beat yields zero or one output beat,
// an end beat one or two. The block accepts one input beat per clock while
// the queue has room: the accepted beat sits in an input register, where
// the label counters are updated and up to two result beats are formed,
// and those results go into a three-entry output queue. The input stays
// ready as long as the queue holds at most one beat, so a steady stream
// runs at one beat per cycle; an end beat with a non-empty last label
// costs one extra output beat, and a stalled output side fills the queue
// and then holds off the input.
module dns_name_label_encoder_core
    import dnsenc_pkg::*;
#(
    parameter int MAX_NAME_BYTES  = 256,
    parameter int MAX_LABEL_BYTES = 63
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    // Offsets must hold label_start + label_length + 1 at its largest,
    // so that the overflow check sees the full value.
    localparam int OFF_W = $clog2(MAX_NAME_BYTES + MAX_LABEL_BYTES + 2);
    localparam int LEN_W = $clog2(MAX_LABEL_BYTES + 1);
    localparam int EXT_W = (OFF_W > 8) ? OFF_W : 8;

    localparam logic [OFF_W-1:0] NAME_LIMIT  = OFF_W'(MAX_NAME_BYTES);
    localparam logic [LEN_W-1:0] LABEL_LIMIT = LEN_W'(MAX_LABEL_BYTES);

    // Input register.
    logic     stg_valid_reg;
    logic     stg_valid_next;
    in_beat_t stg_data_reg;

    // Per-name state.
    logic [OFF_W-1:0] label_start_reg;
    logic [OFF_W-1:0] label_start_next;
    logic [LEN_W-1:0] label_length_reg;
    logic [LEN_W-1:0] label_length_next;
    logic             error_seen_reg;
    logic             error_seen_next;

    // Output queue; entry 0 is the head.
    out_beat_t        q_reg [3];
    out_beat_t        q_next [3];
    logic [1:0]       q_count_reg;
    logic [1:0]       q_count_next;

    logic             stg_fire;
    logic             pop;
    logic             q_has_room;

    // Results formed in the input register stage.
    logic [1:0]       res_count;
    out_beat_t        res0;
    out_beat_t        res1;
    logic [OFF_W-1:0] next_off;
    logic [OFF_W-1:0] term_off;
    logic [EXT_W-1:0] start_ext;
    logic [EXT_W-1:0] next_ext;
    logic [1:0]       base_count;

    // The queue can take the worst case of two results when at most one
    // beat is waiting; this uses registered state only.
    assign q_has_room = (q_count_reg <= 2'd1);
    assign stg_fire   = stg_valid_reg && q_has_room;
    assign in_ready   = !stg_valid_reg || q_has_room;
    assign pop        = (q_count_reg != 2'd0) && out_ready;

    assign out_valid  = (q_count_reg != 2'd0);
    assign out_data   = q_reg[0];

    assign stg_valid_next = (in_valid && in_ready) ? 1'b1 : (stg_fire ? 1'b0 : stg_valid_reg);

    assign next_off  = label_start_reg + OFF_W'(label_length_reg) + OFF_W'(1);
    assign term_off  = (label_length_reg == '0) ? label_start_reg : next_off;
    assign start_ext = EXT_W'(label_start_reg);
    assign next_ext  = EXT_W'(next_off);

    always_comb
    begin
        res_count         = 2'd0;
        res0              = '0;
        res1              = '0;
        label_start_next  = label_start_reg;
        label_length_next = label_length_reg;
        error_seen_next   = error_seen_reg;

        if (stg_fire)
        begin
            if (stg_data_reg.is_end)
            begin
                res_count = 2'd1;
                if (error_seen_reg || (term_off >= NAME_LIMIT))
                begin
                    res0.name_done  = 1'b1;
                    res0.name_error = 1'b1;
                end
                else if (label_length_reg == '0)
                begin
                    res0.write_offset = start_ext[7:0];
                    res0.write_value  = ZERO_BYTE;
                    res0.write_valid  = 1'b1;
                    res0.name_done    = 1'b1;
                end
                else
                begin
                    res_count         = 2'd2;
                    res0.write_offset = start_ext[7:0];
                    res0.write_value  = 8'(label_length_reg);
                    res0.write_valid  = 1'b1;
                    res1.write_offset = next_ext[7:0];
                    res1.write_value  = ZERO_BYTE;
                    res1.write_valid  = 1'b1;
                    res1.name_done    = 1'b1;
                end
                // Every end beat starts a fresh name.
                label_start_next  = '0;
                label_length_next = '0;
                error_seen_next   = 1'b0;
            end
            else if (!error_seen_reg)
            begin
                if (stg_data_reg.character == DOT_CHAR)
                begin
                    if (label_length_reg == '0)
                    begin
                        error_seen_next = 1'b1;
                    end
                    else
                    begin
                        res_count         = 2'd1;
                        res0.write_offset = start_ext[7:0];
                        res0.write_value  = 8'(label_length_reg);
                        res0.write_valid  = 1'b1;
                        label_start_next  = next_off;
                        label_length_next = '0;
                    end
                end
                else if ((label_length_reg == LABEL_LIMIT) || (next_off >= NAME_LIMIT))
                begin
                    error_seen_next = 1'b1;
                end
                else
                begin
                    res_count         = 2'd1;
                    res0.write_offset = next_ext[7:0];
                    res0.write_value  = stg_data_reg.character;
                    res0.write_valid  = 1'b1;
                    label_length_next = label_length_reg + LEN_W'(1);
                end
            end
        end
    end

    // Queue update: pop shifts toward the head, then new results append.
    always_comb
    begin
        q_next     = q_reg;
        base_count = q_count_reg;
        if (pop)
        begin
            q_next[0]  = q_reg[1];
            q_next[1]  = q_reg[2];
            base_count = q_count_reg - 2'd1;
        end
        if (stg_fire)
        begin
            // A firing stage implies at most one beat waiting.
            if (base_count == 2'd0)
            begin
                if (res_count != 2'd0)
                begin
                    q_next[0] = res0;
                    q_next[1] = res1;
                end
            end
            else
            begin
                if (res_count != 2'd0)
                begin
                    q_next[1] = res0;
                    q_next[2] = res1;
                end
            end
        end
        q_count_next = base_count + (stg_fire ? res_count : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg    <= 1'b0;
            label_start_reg  <= '0;
            label_length_reg <= '0;
            error_seen_reg   <= 1'b0;
            q_count_reg      <= 2'd0;
        end
        else
        begin
            stg_valid_reg    <= stg_valid_next;
            label_start_reg  <= label_start_next;
            label_length_reg <= label_length_next;
            error_seen_reg   <= error_seen_next;
            q_count_reg      <= q_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stg_data_reg <= in_data;
        end
        q_reg <= q_next;
    end

endmodule

// ===== hw/rtl/dnsenc_checker.sv =====
// Port-level checker for the DNS name wire-format encoder, bound to the top.
// Depends on dnsenc_pkg for the beat types.
module dnsenc_checker
    import dnsenc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_beat_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_beat_t out_data
);

    // A stalled output beat must stay offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    // A rejected name reports one empty closing beat.
    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.name_error |->
            out_data.name_done && !out_data.write_valid &&
            (out_data.write_offset == 8'd0) && (out_data.write_value == 8'd0))
        else $error("error beat is not a bare closing beat");

    // Only the closing beat of a rejected name carries no write.
    a_nowrite_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.write_valid |-> out_data.name_error)
        else $error("beat without write on an accepted name");

    // A successful name closes with the zero terminator.
    a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.name_done && !out_data.name_error |->
            out_data.write_valid && (out_data.write_value == 8'd0))
        else $error("closing beat is not a zero terminator");

    // No output beat is offered as reset is released.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("output beat right after reset");

endmodule

bind dns_name_label_encoder_core dnsenc_checker u_dnsenc_checker (.*);
